@@ rtl/simp2d_pkg.sv @@
// Shared package for the 2-D Simpson integrator: field widths, saturation limits,
// the controller state type and the command/status bundles.
// Has no dependencies.
package simp2d_pkg;

   localparam int MAX_INTERVALS = 1024;
   localparam int MIN_INTERVALS = 2;
   localparam int BOUND_W       = 16;
   localparam int INTERVALS_W   = 11;
   localparam int FRAC_EXT      = 8;
   localparam int DIFF_W        = BOUND_W + 1;
   localparam int DIVIDEND_W    = DIFF_W + FRAC_EXT;
   localparam int STEP_W        = BOUND_W + FRAC_EXT;
   localparam int STEP_MAG_W    = STEP_W - 1;
   localparam int DIV_CNT_W     = $clog2(STEP_W);
   localparam int PROD_W        = 2 * STEP_W;
   localparam int SHAMT_W       = 3;
   localparam int TERM_W        = PROD_W + 4;
   localparam int ACC_W         = 64;
   localparam int SUM_W         = ACC_W + 1;
   localparam int HALF_W        = 32;
   localparam int HPROD_W       = 2 * STEP_MAG_W;
   localparam int PP_W          = HALF_W + STEP_MAG_W;
   localparam int PP_SHIFT_W    = 6;
   localparam int BIG_W         = ACC_W + HPROD_W;
   localparam int QUO_W         = BIG_W - HALF_W;
   localparam int REM9_W        = 4;
   localparam int DIVISOR9      = 9;
   localparam int MUL_PARTS     = 4;
   localparam int CNT_W         = $clog2(MUL_PARTS);

   // Division by nine works on 26-bit chunks; the 78-bit quotient takes three of them.
   // Each chunk quotient is floor(cur * RECIP9 / 2^33), exact for cur below 9 * 2^26.
   localparam int DIV9_CHUNK_W  = 26;
   localparam int DIV9_STEPS    = QUO_W / DIV9_CHUNK_W;
   localparam int DIV9_CUR_W    = REM9_W + DIV9_CHUNK_W;
   localparam int DIV9_PROD_W   = 2 * DIV9_CUR_W;
   localparam int RECIP9_SHIFT  = 33;
   localparam logic [DIV9_CUR_W-1:0] RECIP9 = 30'd954437177;

   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START_X,
      ST_WAIT_X,
      ST_START_Y,
      ST_WAIT_Y,
      ST_WALK_INIT,
      ST_WALK,
      ST_DRAIN,
      ST_HMUL,
      ST_MUL,
      ST_DIV9_INIT,
      ST_DIV9,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       load;
      logic       div_start;
      logic       div_sel_y;
      logic       take_step;
      logic       walk_init;
      logic       walk_step;
      logic       hmul;
      logic       mul_step;
      logic [1:0] mul_part;
      logic       div9_init;
      logic       div9_step;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic last_point;
      logic pipe_empty;
   } status_type;

endpackage

@@ rtl/simp2d_stepdiv.sv @@
// Iterative signed divider for the grid step: one quotient bit per cycle,
// truncating toward zero. Depends on simp2d_pkg.
module simp2d_stepdiv (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   input  logic signed [simp2d_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [simp2d_pkg::INTERVALS_W-1:0]         divisor,
   output logic [simp2d_pkg::STEP_W-1:0]              quotient,
   output logic                                       done
);

   logic                                  busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic [simp2d_pkg::DIV_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                                  neg_ff, neg_in;
   logic [simp2d_pkg::STEP_W-1:0]         work_ff, work_in;
   logic [simp2d_pkg::INTERVALS_W-1:0]    rem_ff, rem_in;
   logic [simp2d_pkg::INTERVALS_W-1:0]    divisor_ff, divisor_in;
   logic [simp2d_pkg::DIVIDEND_W-1:0]     dividend_abs;
   logic [simp2d_pkg::INTERVALS_W:0]      trial;
   logic                                  fits;

   always_comb begin
      dividend_abs = dividend[simp2d_pkg::DIVIDEND_W-1] ? -dividend : dividend;
      trial        = {rem_ff, work_ff[simp2d_pkg::STEP_W-1]};
      fits         = trial >= {1'b0, divisor_ff};

      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      neg_in     = neg_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;

      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         neg_in     = dividend[simp2d_pkg::DIVIDEND_W-1];
         work_in    = dividend_abs[simp2d_pkg::STEP_W-1:0];
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         // Restoring step: shift the next dividend bit into the remainder.
         rem_in  = fits ? simp2d_pkg::INTERVALS_W'(trial - {1'b0, divisor_ff})
                        : trial[simp2d_pkg::INTERVALS_W-1:0];
         work_in = {work_ff[simp2d_pkg::STEP_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == simp2d_pkg::DIV_CNT_W'(simp2d_pkg::STEP_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      neg_ff     <= neg_in;
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign quotient = neg_ff ? -work_ff : work_ff;
   assign done     = done_ff;

endmodule

@@ rtl/simp2d_datapath.sv @@
// Datapath of the 2-D Simpson integrator: bounds and steps, grid walk with a
// registered multiply and saturating accumulate, final scaling and result register.
// Depends on simp2d_pkg and simp2d_stepdiv.
module simp2d_datapath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  simp2d_pkg::cmd_type                      cmd,
   output simp2d_pkg::status_type                   status,
   input  logic signed [simp2d_pkg::BOUND_W-1:0]    req_x_start,
   input  logic signed [simp2d_pkg::BOUND_W-1:0]    req_x_end,
   input  logic signed [simp2d_pkg::BOUND_W-1:0]    req_y_start,
   input  logic signed [simp2d_pkg::BOUND_W-1:0]    req_y_end,
   input  logic [simp2d_pkg::INTERVALS_W-1:0]       req_intervals,
   output logic signed [simp2d_pkg::ACC_W-1:0]      rsp_integral,
   output logic                                     rsp_overflow
);

   function automatic logic [1:0] weight_shift(
      input logic [simp2d_pkg::INTERVALS_W-1:0] k,
      input logic [simp2d_pkg::INTERVALS_W-1:0] n
   );
      logic [1:0] sh;
      if (k == '0 || k == n) begin
         sh = 2'd0;
      end else if (k[0]) begin
         sh = 2'd2;
      end else begin
         sh = 2'd1;
      end
      return sh;
   endfunction

   // Item setup.
   logic [simp2d_pkg::INTERVALS_W-1:0]         n_ff, n_in, n_lim;
   logic signed [simp2d_pkg::DIFF_W-1:0]       diff_x, diff_y;
   logic signed [simp2d_pkg::DIVIDEND_W-1:0]   dividend_x_ff, dividend_x_in;
   logic signed [simp2d_pkg::DIVIDEND_W-1:0]   dividend_y_ff, dividend_y_in;
   logic signed [simp2d_pkg::STEP_W-1:0]       x0_ff, x0_in, y0_ff, y0_in;
   logic signed [simp2d_pkg::STEP_W-1:0]       h1_ff, h1_in, h2_ff, h2_in;
   logic [simp2d_pkg::STEP_W-1:0]              div_quotient;
   logic                                       div_done;

   // Grid walk.
   logic [simp2d_pkg::INTERVALS_W-1:0]         i_ff, i_in, j_ff, j_in;
   logic signed [simp2d_pkg::STEP_W-1:0]       xi_ff, xi_in, yj_ff, yj_in;
   logic                                       s1_valid_ff, s1_valid_in;
   logic signed [simp2d_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic [simp2d_pkg::SHAMT_W-1:0]             shamt_ff, shamt_in;
   logic signed [simp2d_pkg::TERM_W-1:0]       term;
   logic signed [simp2d_pkg::SUM_W-1:0]        sum;
   logic signed [simp2d_pkg::ACC_W-1:0]        acc_ff, acc_in;
   logic                                       acc_ovf_ff, acc_ovf_in;

   // Scaling.
   logic [simp2d_pkg::STEP_W-1:0]              h1_abs, h2_abs;
   logic [simp2d_pkg::HPROD_W-1:0]             hprod_ff, hprod_in;
   logic [simp2d_pkg::ACC_W-1:0]               mag_ff, mag_in;
   logic                                       neg_ff, neg_in;
   logic [simp2d_pkg::HALF_W-1:0]              m_half;
   logic [simp2d_pkg::STEP_MAG_W-1:0]          h_half;
   logic [simp2d_pkg::PP_W-1:0]                pp;
   logic [simp2d_pkg::PP_SHIFT_W-1:0]          pp_shift;
   logic [simp2d_pkg::BIG_W-1:0]               big_ff, big_in;
   logic [simp2d_pkg::QUO_W-1:0]               quo_ff, quo_in;
   logic [simp2d_pkg::REM9_W-1:0]              rem9_ff, rem9_in;
   logic [simp2d_pkg::DIV9_CUR_W-1:0]          cur9;
   logic [simp2d_pkg::DIV9_PROD_W-1:0]         prod9;
   logic [simp2d_pkg::DIV9_CHUNK_W-1:0]        q9;
   logic [simp2d_pkg::ACC_W-1:0]               q_mag;
   logic [simp2d_pkg::ACC_W-1:0]               res;
   logic                                       res_sat;
   logic [simp2d_pkg::ACC_W-1:0]               rsp_integral_ff, rsp_integral_in;
   logic                                       rsp_overflow_ff, rsp_overflow_in;

   simp2d_stepdiv u_stepdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (cmd.div_sel_y ? dividend_y_ff : dividend_x_ff),
      .divisor  (n_ff),
      .quotient (div_quotient),
      .done     (div_done)
   );

   always_comb begin
      // Interval count: zero becomes the minimum, large counts clamp, odd rounds up.
      if (req_intervals == '0) begin
         n_lim = simp2d_pkg::INTERVALS_W'(simp2d_pkg::MIN_INTERVALS);
      end else if (req_intervals > simp2d_pkg::INTERVALS_W'(simp2d_pkg::MAX_INTERVALS)) begin
         n_lim = simp2d_pkg::INTERVALS_W'(simp2d_pkg::MAX_INTERVALS);
      end else begin
         n_lim = req_intervals;
      end
      diff_x = simp2d_pkg::DIFF_W'(req_x_end) - simp2d_pkg::DIFF_W'(req_x_start);
      diff_y = simp2d_pkg::DIFF_W'(req_y_end) - simp2d_pkg::DIFF_W'(req_y_start);

      n_in          = n_ff;
      dividend_x_in = dividend_x_ff;
      dividend_y_in = dividend_y_ff;
      x0_in         = x0_ff;
      y0_in         = y0_ff;
      h1_in         = h1_ff;
      h2_in         = h2_ff;

      if (cmd.load) begin
         n_in          = n_lim + simp2d_pkg::INTERVALS_W'(n_lim[0]);
         dividend_x_in = {diff_x, {simp2d_pkg::FRAC_EXT{1'b0}}};
         dividend_y_in = {diff_y, {simp2d_pkg::FRAC_EXT{1'b0}}};
         x0_in         = {req_x_start, {simp2d_pkg::FRAC_EXT{1'b0}}};
         y0_in         = {req_y_start, {simp2d_pkg::FRAC_EXT{1'b0}}};
      end
      if (cmd.take_step) begin
         if (cmd.div_sel_y) begin
            h2_in = div_quotient;
         end else begin
            h1_in = div_quotient;
         end
      end
   end

   always_comb begin
      i_in        = i_ff;
      j_in        = j_ff;
      xi_in       = xi_ff;
      yj_in       = yj_ff;
      s1_valid_in = 1'b0;
      prod_in     = prod_ff;
      shamt_in    = shamt_ff;
      acc_in      = acc_ff;
      acc_ovf_in  = acc_ovf_ff;

      term = simp2d_pkg::TERM_W'(prod_ff) <<< shamt_ff;
      sum  = simp2d_pkg::SUM_W'(acc_ff) + simp2d_pkg::SUM_W'(term);

      if (cmd.walk_init) begin
         i_in       = '0;
         j_in       = '0;
         xi_in      = x0_ff;
         yj_in      = y0_ff;
         acc_in     = '0;
         acc_ovf_in = 1'b0;
      end else if (cmd.walk_step) begin
         s1_valid_in = 1'b1;
         prod_in     = xi_ff * yj_ff;
         shamt_in    = simp2d_pkg::SHAMT_W'(weight_shift(i_ff, n_ff))
                     + simp2d_pkg::SHAMT_W'(weight_shift(j_ff, n_ff));
         if (j_ff == n_ff) begin
            j_in  = '0;
            i_in  = i_ff + 1'b1;
            yj_in = y0_ff;
            xi_in = xi_ff + h1_ff;
         end else begin
            j_in  = j_ff + 1'b1;
            yj_in = yj_ff + h2_ff;
         end
      end

      // A term that leaves the 64-bit range clamps the sum; later terms
      // continue from the clamped value.
      if (s1_valid_ff) begin
         if (sum[simp2d_pkg::ACC_W] != sum[simp2d_pkg::ACC_W-1]) begin
            acc_ovf_in = 1'b1;
            acc_in     = sum[simp2d_pkg::ACC_W] ? simp2d_pkg::ACC_MIN : simp2d_pkg::ACC_MAX;
         end else begin
            acc_in = sum[simp2d_pkg::ACC_W-1:0];
         end
      end
   end

   always_comb begin
      h1_abs = h1_ff[simp2d_pkg::STEP_W-1] ? -h1_ff : h1_ff;
      h2_abs = h2_ff[simp2d_pkg::STEP_W-1] ? -h2_ff : h2_ff;

      m_half   = cmd.mul_part[1] ? mag_ff[simp2d_pkg::ACC_W-1:simp2d_pkg::HALF_W]
                                 : mag_ff[simp2d_pkg::HALF_W-1:0];
      h_half   = cmd.mul_part[0] ? hprod_ff[simp2d_pkg::HPROD_W-1:simp2d_pkg::STEP_MAG_W]
                                 : hprod_ff[simp2d_pkg::STEP_MAG_W-1:0];
      pp       = m_half * h_half;
      pp_shift = (cmd.mul_part[1] ? simp2d_pkg::PP_SHIFT_W'(simp2d_pkg::HALF_W)
                                  : simp2d_pkg::PP_SHIFT_W'(0))
               + (cmd.mul_part[0] ? simp2d_pkg::PP_SHIFT_W'(simp2d_pkg::STEP_MAG_W)
                                  : simp2d_pkg::PP_SHIFT_W'(0));

      cur9  = {rem9_ff, quo_ff[simp2d_pkg::QUO_W-1 -: simp2d_pkg::DIV9_CHUNK_W]};
      prod9 = simp2d_pkg::DIV9_PROD_W'(cur9) * simp2d_pkg::DIV9_PROD_W'(simp2d_pkg::RECIP9);
      q9    = prod9[simp2d_pkg::RECIP9_SHIFT +: simp2d_pkg::DIV9_CHUNK_W];

      q_mag   = quo_ff[simp2d_pkg::ACC_W-1:0];
      res_sat = 1'b0;
      if (|quo_ff[simp2d_pkg::QUO_W-1:simp2d_pkg::ACC_W]) begin
         res_sat = 1'b1;
         res     = neg_ff ? simp2d_pkg::ACC_MIN : simp2d_pkg::ACC_MAX;
      end else if (neg_ff) begin
         if (q_mag > simp2d_pkg::ACC_MIN) begin
            res_sat = 1'b1;
            res     = simp2d_pkg::ACC_MIN;
         end else begin
            res = -q_mag;
         end
      end else if (q_mag[simp2d_pkg::ACC_W-1]) begin
         res_sat = 1'b1;
         res     = simp2d_pkg::ACC_MAX;
      end else begin
         res = q_mag;
      end

      hprod_in        = hprod_ff;
      mag_in          = mag_ff;
      neg_in          = neg_ff;
      big_in          = big_ff;
      quo_in          = quo_ff;
      rem9_in         = rem9_ff;
      rsp_integral_in = rsp_integral_ff;
      rsp_overflow_in = rsp_overflow_ff;

      if (cmd.hmul) begin
         hprod_in = h1_abs[simp2d_pkg::STEP_MAG_W-1:0] * h2_abs[simp2d_pkg::STEP_MAG_W-1:0];
         mag_in   = acc_ff[simp2d_pkg::ACC_W-1] ? -acc_ff : acc_ff;
         neg_in   = acc_ff[simp2d_pkg::ACC_W-1] ^ h1_ff[simp2d_pkg::STEP_W-1]
                  ^ h2_ff[simp2d_pkg::STEP_W-1];
         big_in   = '0;
      end
      if (cmd.mul_step) begin
         big_in = big_ff + (simp2d_pkg::BIG_W'(pp) << pp_shift);
      end
      // The low 32 bits of the product only fall below the binary point. The rest is
      // divided by nine one 26-bit chunk per cycle: the chunk quotient comes from a
      // reciprocal multiply and its remainder is carried into the next chunk.
      if (cmd.div9_init) begin
         quo_in  = big_ff[simp2d_pkg::BIG_W-1:simp2d_pkg::HALF_W];
         rem9_in = '0;
      end
      if (cmd.div9_step) begin
         rem9_in = simp2d_pkg::REM9_W'(cur9 - simp2d_pkg::DIV9_CUR_W'(q9)
                                            * simp2d_pkg::DIV9_CUR_W'(simp2d_pkg::DIVISOR9));
         quo_in  = {quo_ff[simp2d_pkg::QUO_W-simp2d_pkg::DIV9_CHUNK_W-1:0], q9};
      end
      if (cmd.finish) begin
         rsp_integral_in = res;
         rsp_overflow_in = acc_ovf_ff | res_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff            <= n_in;
      dividend_x_ff   <= dividend_x_in;
      dividend_y_ff   <= dividend_y_in;
      x0_ff           <= x0_in;
      y0_ff           <= y0_in;
      h1_ff           <= h1_in;
      h2_ff           <= h2_in;
      i_ff            <= i_in;
      j_ff            <= j_in;
      xi_ff           <= xi_in;
      yj_ff           <= yj_in;
      prod_ff         <= prod_in;
      shamt_ff        <= shamt_in;
      acc_ff          <= acc_in;
      acc_ovf_ff      <= acc_ovf_in;
      hprod_ff        <= hprod_in;
      mag_ff          <= mag_in;
      neg_ff          <= neg_in;
      big_ff          <= big_in;
      quo_ff          <= quo_in;
      rem9_ff         <= rem9_in;
      rsp_integral_ff <= rsp_integral_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign status.div_done   = div_done;
   assign status.last_point = (i_ff == n_ff) && (j_ff == n_ff);
   assign status.pipe_empty = !s1_valid_ff;

   assign rsp_integral = rsp_integral_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

@@ rtl/simp2d_ctrl.sv @@
// Controller of the 2-D Simpson integrator: sequences the step divisions, the
// grid walk and the final scaling, and owns both handshakes. Depends on simp2d_pkg.
module simp2d_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output simp2d_pkg::cmd_type     cmd,
   input  simp2d_pkg::status_type  status
);

   simp2d_pkg::state_type             state_ff, state_in;
   logic [simp2d_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         simp2d_pkg::ST_IDLE: begin
            if (req_valid) state_in = simp2d_pkg::ST_START_X;
         end
         simp2d_pkg::ST_START_X: state_in = simp2d_pkg::ST_WAIT_X;
         simp2d_pkg::ST_WAIT_X: begin
            if (status.div_done) state_in = simp2d_pkg::ST_START_Y;
         end
         simp2d_pkg::ST_START_Y: state_in = simp2d_pkg::ST_WAIT_Y;
         simp2d_pkg::ST_WAIT_Y: begin
            if (status.div_done) state_in = simp2d_pkg::ST_WALK_INIT;
         end
         simp2d_pkg::ST_WALK_INIT: state_in = simp2d_pkg::ST_WALK;
         simp2d_pkg::ST_WALK: begin
            if (status.last_point) state_in = simp2d_pkg::ST_DRAIN;
         end
         simp2d_pkg::ST_DRAIN: begin
            if (status.pipe_empty) state_in = simp2d_pkg::ST_HMUL;
         end
         simp2d_pkg::ST_HMUL: state_in = simp2d_pkg::ST_MUL;
         simp2d_pkg::ST_MUL: begin
            if (cnt_ff == simp2d_pkg::CNT_W'(simp2d_pkg::MUL_PARTS - 1)) begin
               state_in = simp2d_pkg::ST_DIV9_INIT;
            end
         end
         simp2d_pkg::ST_DIV9_INIT: state_in = simp2d_pkg::ST_DIV9;
         simp2d_pkg::ST_DIV9: begin
            if (cnt_ff == simp2d_pkg::CNT_W'(simp2d_pkg::DIV9_STEPS - 1)) begin
               state_in = simp2d_pkg::ST_FINISH;
            end
         end
         simp2d_pkg::ST_FINISH: begin
            if (out_free) state_in = simp2d_pkg::ST_IDLE;
         end
         default: state_in = simp2d_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      case (state_ff)
         simp2d_pkg::ST_IDLE: begin
            cmd.load = req_valid;
         end
         simp2d_pkg::ST_START_X: begin
            cmd.div_start = 1'b1;
         end
         simp2d_pkg::ST_WAIT_X: begin
            cmd.take_step = status.div_done;
         end
         simp2d_pkg::ST_START_Y: begin
            cmd.div_start = 1'b1;
            cmd.div_sel_y = 1'b1;
         end
         simp2d_pkg::ST_WAIT_Y: begin
            cmd.div_sel_y = 1'b1;
            cmd.take_step = status.div_done;
         end
         simp2d_pkg::ST_WALK_INIT: begin
            cmd.walk_init = 1'b1;
         end
         simp2d_pkg::ST_WALK: begin
            cmd.walk_step = 1'b1;
         end
         simp2d_pkg::ST_DRAIN: begin
         end
         simp2d_pkg::ST_HMUL: begin
            cmd.hmul = 1'b1;
            cnt_in   = '0;
         end
         simp2d_pkg::ST_MUL: begin
            cmd.mul_step = 1'b1;
            cmd.mul_part = cnt_ff[1:0];
            cnt_in       = cnt_ff + 1'b1;
         end
         simp2d_pkg::ST_DIV9_INIT: begin
            cmd.div9_init = 1'b1;
            cnt_in        = '0;
         end
         simp2d_pkg::ST_DIV9: begin
            cmd.div9_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
         end
         simp2d_pkg::ST_FINISH: begin
            // The result register is loaded only once the previous result has left.
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= simp2d_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != simp2d_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/simpson_2d_integrator.sv @@
// Top level of the 2-D Simpson integrator: controller plus datapath.
// Depends on simp2d_pkg, simp2d_ctrl and simp2d_datapath.
//
// Integrates x*y over a rectangle given in signed Q8.8 with the composite
// Simpson rule on an n x n grid (n rounded up to even, 2 to 1024) and returns
// one signed Q32.32 result with an overflow flag per transfer. Items are
// processed one at a time: the next input is taken only after the previous
// item's result has been loaded into the output register. The time is set by
// the single multiply-accumulate unit that visits one grid point per cycle.
// The rest is two step divisions, a partial-product multiply, a division by
// nine and the sequencing states. A new item is taken while the previous
// result still waits in the output register; an item whose result is ready
// while that register is still held stalls until it is free.
module simpson_2d_integrator (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [simp2d_pkg::BOUND_W-1:0]    req_x_start,
   input  logic signed [simp2d_pkg::BOUND_W-1:0]    req_x_end,
   input  logic signed [simp2d_pkg::BOUND_W-1:0]    req_y_start,
   input  logic signed [simp2d_pkg::BOUND_W-1:0]    req_y_end,
   input  logic [simp2d_pkg::INTERVALS_W-1:0]       req_intervals,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [simp2d_pkg::ACC_W-1:0]      rsp_integral,
   output logic                                     rsp_overflow
);

   simp2d_pkg::cmd_type     cmd;
   simp2d_pkg::status_type  status;

   simp2d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   simp2d_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_x_start   (req_x_start),
      .req_x_end     (req_x_end),
      .req_y_start   (req_y_start),
      .req_y_end     (req_y_end),
      .req_intervals (req_intervals),
      .rsp_integral  (rsp_integral),
      .rsp_overflow  (rsp_overflow)
   );

endmodule

@@ sim/tb_simpson_2d_integrator.sv @@
// Self-checking testbench for simpson_2d_integrator: directed table, then random rectangles.
// Each result is checked against a fixed-point Simpson predictor kept in this file.
// Depends on simp2d_pkg and the simpson_2d_integrator RTL.
`timescale 1ns / 100ps

module tb_simpson_2d_integrator;

   localparam int NUM_DIRECTED    = 15;
   localparam int NUM_RANDOM      = 100;
   localparam int HOLD_CYCLES     = 4000;
   localparam int DRAIN_CYCLES    = 300;
   localparam int WATCHDOG_CYCLES = 3_200_000;
   localparam int MAX_REPORTS     = 10;

   typedef struct packed {
      logic [simp2d_pkg::BOUND_W-1:0]     x_start;
      logic [simp2d_pkg::BOUND_W-1:0]     x_end;
      logic [simp2d_pkg::BOUND_W-1:0]     y_start;
      logic [simp2d_pkg::BOUND_W-1:0]     y_end;
      logic [simp2d_pkg::INTERVALS_W-1:0] intervals;
      logic                               typed;
      logic [simp2d_pkg::ACC_W-1:0]       integral;
      logic                               overflow;
   } rect_row_type;

   typedef struct {
      logic signed [simp2d_pkg::ACC_W-1:0] integral;
      logic                                overflow;
   } integral_result_type;

   // Rows marked typed carry a result worked out by hand; the rest go through the predictor.
   localparam rect_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 11'd5,    1'b1, 64'd0, 1'b0},
      '{16'h0000, 16'h0100, 16'h0000, 16'h0100, 11'd2,    1'b1, 64'h4000_0000, 1'b0},
      '{16'h0000, 16'h0100, 16'h0000, 16'h0100, 11'd1,    1'b1, 64'h4000_0000, 1'b0},
      '{16'h0000, 16'h0100, 16'h0000, 16'h0100, 11'd0,    1'b1, 64'h4000_0000, 1'b0},
      '{16'h0100, 16'h0000, 16'h0000, 16'h0100, 11'd2,    1'b1,
        64'hFFFF_FFFF_C000_0000, 1'b0},
      '{16'h0000, 16'h0200, 16'h0000, 16'h0100, 11'd3,    1'b1, 64'h1_0000_0000, 1'b0},
      '{16'hFF00, 16'h0100, 16'h0000, 16'h0100, 11'd2,    1'b1, 64'd0, 1'b0},
      '{16'h8000, 16'h7FFF, 16'h1234, 16'h1234, 11'd4,    1'b1, 64'd0, 1'b0},
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 11'd128,  1'b1, 64'd0, 1'b1},
      '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 11'd200,  1'b1, 64'd0, 1'b1},
      '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 11'd2,    1'b0, 64'd0, 1'b0},
      '{16'hC000, 16'h3FFF, 16'h0080, 16'hFF80, 11'd7,    1'b0, 64'd0, 1'b0},
      '{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 11'd10,   1'b0, 64'd0, 1'b0},
      '{16'h1357, 16'hE9AC, 16'h00FF, 16'h7F00, 11'd96,   1'b0, 64'd0, 1'b0},
      '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 11'd2047, 1'b0, 64'd0, 1'b0}
   };

   logic                                      clock;
   logic                                      reset         = 1'b1;
   logic                                      req_valid     = 1'b0;
   logic                                      req_stall;
   logic signed [simp2d_pkg::BOUND_W-1:0]     req_x_start   = '0;
   logic signed [simp2d_pkg::BOUND_W-1:0]     req_x_end     = '0;
   logic signed [simp2d_pkg::BOUND_W-1:0]     req_y_start   = '0;
   logic signed [simp2d_pkg::BOUND_W-1:0]     req_y_end     = '0;
   logic [simp2d_pkg::INTERVALS_W-1:0]        req_intervals = '0;
   logic                                      rsp_valid;
   logic                                      rsp_stall     = 1'b0;
   logic signed [simp2d_pkg::ACC_W-1:0]       rsp_integral;
   logic                                      rsp_overflow;

   integral_result_type pending_integrals[$];
   int unsigned         failures      = 0;
   int unsigned         send_idle_pct = 30;
   int unsigned         recv_idle_pct = 30;
   bit                  hold_request  = 1'b0;
   int unsigned         hold_left     = 0;
   int unsigned         quiet_cycles  = 0;

   simpson_2d_integrator u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_x_start   (req_x_start),
      .req_x_end     (req_x_end),
      .req_y_start   (req_y_start),
      .req_y_end     (req_y_end),
      .req_intervals (req_intervals),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_integral  (rsp_integral),
      .rsp_overflow  (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Composite Simpson sum of x*y over the grid, then scaled by hx*hy/9 and saturated.
   function automatic integral_result_type predict_xy_integral(
      input logic [simp2d_pkg::BOUND_W-1:0] xs, input logic [simp2d_pkg::BOUND_W-1:0] xe,
      input logic [simp2d_pkg::BOUND_W-1:0] ys, input logic [simp2d_pkg::BOUND_W-1:0] ye,
      input logic [simp2d_pkg::INTERVALS_W-1:0] count);
      longint                            n, step_x, step_y, x0, y0, xi, yj, wi, wj;
      longint                            term, sum, step_mag;
      logic signed [simp2d_pkg::ACC_W:0] sum_ext;
      logic signed [127:0]               sum_wide;
      logic [127:0]                      product, quotient;
      logic                              ovf, neg;
      integral_result_type               res;
      n = count;
      if (n == 0) n = simp2d_pkg::MIN_INTERVALS;
      if (n > simp2d_pkg::MAX_INTERVALS) n = simp2d_pkg::MAX_INTERVALS;
      if (n % 2 != 0) n++;
      step_x = ((longint'($signed(xe)) - longint'($signed(xs))) * 256) / n;
      step_y = ((longint'($signed(ye)) - longint'($signed(ys))) * 256) / n;
      x0 = longint'($signed(xs)) * 256;
      y0 = longint'($signed(ys)) * 256;
      sum = 0;
      ovf = 1'b0;
      for (longint i = 0; i <= n; i++) begin
         xi = x0 + i * step_x;
         wi = (i == 0 || i == n) ? 1 : ((i % 2 != 0) ? 4 : 2);
         for (longint j = 0; j <= n; j++) begin
            yj = y0 + j * step_y;
            wj = (j == 0 || j == n) ? 1 : ((j % 2 != 0) ? 4 : 2);
            term = wi * wj * xi * yj;
            sum_ext = sum + term;
            if (sum_ext[simp2d_pkg::ACC_W] != sum_ext[simp2d_pkg::ACC_W-1]) begin
               ovf = 1'b1;
               sum = sum_ext[simp2d_pkg::ACC_W] ? simp2d_pkg::ACC_MIN : simp2d_pkg::ACC_MAX;
            end else begin
               sum = sum_ext[simp2d_pkg::ACC_W-1:0];
            end
         end
      end
      neg = (sum < 0) ^ (step_x < 0) ^ (step_y < 0);
      sum_wide = sum;
      if (sum_wide < 0) sum_wide = -sum_wide;
      step_mag = (step_x < 0 ? -step_x : step_x) * (step_y < 0 ? -step_y : step_y);
      product = sum_wide * 128'(step_mag);
      quotient = product / (128'd9 << 32);
      if (!neg && quotient > 128'(simp2d_pkg::ACC_MAX)) begin
         ovf = 1'b1;
         res.integral = simp2d_pkg::ACC_MAX;
      end else if (neg && quotient > 128'(simp2d_pkg::ACC_MIN)) begin
         ovf = 1'b1;
         res.integral = simp2d_pkg::ACC_MIN;
      end else begin
         res.integral = neg ? -quotient[simp2d_pkg::ACC_W-1:0]
                            : quotient[simp2d_pkg::ACC_W-1:0];
      end
      res.overflow = ovf;
      return res;
   endfunction

   function automatic logic [simp2d_pkg::BOUND_W-1:0] pick_bound();
      case ($urandom_range(4))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return {simp2d_pkg::BOUND_W{1'($urandom_range(1))}};
         default: return simp2d_pkg::BOUND_W'($urandom);
      endcase
   endfunction

   task automatic log_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("%t: %s", $realtime, msg);
   endtask

   // Presents one rectangle and waits for its transfer; valid stays high when no gap follows.
   task automatic offer_rect(input logic [simp2d_pkg::BOUND_W-1:0] xs,
                             input logic [simp2d_pkg::BOUND_W-1:0] xe,
                             input logic [simp2d_pkg::BOUND_W-1:0] ys,
                             input logic [simp2d_pkg::BOUND_W-1:0] ye,
                             input logic [simp2d_pkg::INTERVALS_W-1:0] count,
                             input integral_result_type predicted);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_x_start   <= xs;
      req_x_end     <= xe;
      req_y_start   <= ys;
      req_y_end     <= ye;
      req_intervals <= count;
      do @(posedge clock); while (req_stall);
      pending_integrals.push_back(predicted);
   endtask

   // Receiver: random stalls, plus one long hold-off when requested.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      integral_result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_integrals.size() == 0) begin
            log_failure($sformatf("result with nothing pending: integral %h overflow %b",
                                  rsp_integral, rsp_overflow));
         end else begin
            want = pending_integrals.pop_front();
            if (rsp_integral !== want.integral || rsp_overflow !== want.overflow)
               log_failure($sformatf("integral %h overflow %b, expected %h overflow %b",
                                     rsp_integral, rsp_overflow, want.integral,
                                     want.overflow));
         end
      end
   end

   // The watchdog bound must cover a single item at the largest count, during which no transfer happens.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      rect_row_type                       row;
      integral_result_type                predicted;
      logic [simp2d_pkg::BOUND_W-1:0]     xs, xe, ys, ye;
      logic [simp2d_pkg::INTERVALS_W-1:0] count;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_DIRECTED; r++) begin
         row = DIRECTED_ROWS[r];
         if (row.typed) begin
            predicted.integral = row.integral;
            predicted.overflow = row.overflow;
         end else begin
            predicted = predict_xy_integral(row.x_start, row.x_end, row.y_start, row.y_end,
                                            row.intervals);
         end
         offer_rect(row.x_start, row.x_end, row.y_start, row.y_end, row.intervals, predicted);
      end

      for (int k = 0; k < NUM_RANDOM; k++) begin
         if (k == 20) hold_request = 1'b1;
         if (k == 50) begin
            // Let the block drain completely before going on.
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_integrals.size() != 0) @(posedge clock);
         end
         if (k == 65) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (k == 90) begin
            send_idle_pct = 30;
            recv_idle_pct = 30;
         end
         xs = pick_bound();
         xe = pick_bound();
         ys = pick_bound();
         ye = pick_bound();
         count = ($urandom_range(9) == 0)
               ? simp2d_pkg::INTERVALS_W'($urandom_range(32, 130))
               : simp2d_pkg::INTERVALS_W'($urandom_range(0, 31));
         offer_rect(xs, xe, ys, ye, count, predict_xy_integral(xs, xe, ys, ye, count));
      end
      req_valid <= 1'b0;

      while (pending_integrals.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
